[src/sha_pkg.sv]
// shared types, constants and round functions for the sha-256 stream hasher
// no dependencies
`default_nettype none
package sha_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_ABSORB   = 2'd0,
    MODE_INIT     = 2'd1,
    MODE_SNAPSHOT = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_ABSORB = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_SNAP   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

[src/sha_front.sv]
// front stage: takes input items, classifies the mode, drops the unused code
// depends on sha_pkg
`default_nettype none
module sha_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  in_mode_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output sha_pkg::cmd_t    cmd_o
);

  logic          valid_q;
  sha_pkg::cmd_t cmd_q;
  logic          take;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= (in_mode_i != sha_pkg::MODE_UNUSED);
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unique case (in_mode_i)
        sha_pkg::MODE_ABSORB:   cmd_q.kind <= sha_pkg::CMD_ABSORB;
        sha_pkg::MODE_INIT:     cmd_q.kind <= sha_pkg::CMD_INIT;
        default:                cmd_q.kind <= sha_pkg::CMD_SNAP;
      endcase
      cmd_q.data <= in_byte_i;
    end
  end

endmodule
`default_nettype wire

[src/sha_queue.sv]
// short command queue between the front stage and the hashing core
// depends on sha_pkg
`default_nettype none
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_valid_i,
  output logic             wr_ready_o,
  input  wire sha_pkg::cmd_t wr_cmd_i,
  output logic             rd_valid_o,
  input  wire logic        rd_ready_i,
  output sha_pkg::cmd_t    rd_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule
`default_nettype wire

[src/sha_core.sv]
// hashing core: block buffer, padding sequencer, one-round-per-cycle compression,
// digest output register; depends on sha_pkg
`default_nettype none
module sha_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire sha_pkg::cmd_t cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        out_word_o,
  output logic [2:0]         out_index_o,
  output logic               out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_FINISH, ST_EMIT
  } state_e;

  state_e         state_q;
  sha_pkg::hash_t hash_q, base_q, wv_q, sum;
  logic [63:0]    bits_q, len_q;
  logic [511:0]   buf_q, w_q;
  logic [5:0]     fill_q, cnt_q, rnd_q;
  logic [2:0]     idx_q;
  logic           first_q, two_q, snap_q;
  logic [7:0]     pad_byte;
  logic [31:0]    w_new, t1, t2;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_word_o  = base_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  always_comb begin
    if (first_q) begin
      pad_byte = sha_pkg::PadMark;
    end else if (two_q || cnt_q < sha_pkg::LenStart) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_q[63:56];
    end
  end

  // window holds w[t..t+15], oldest word at the top
  assign w_new = sha_pkg::small_s1(w_q[63:32]) + w_q[223:192]
               + sha_pkg::small_s0(w_q[479:448]) + w_q[511:480];
  assign t1 = wv_q[7] + sha_pkg::big_s1(wv_q[4])
            + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
            + sha_pkg::round_k(rnd_q) + w_q[511:480];
  assign t2 = sha_pkg::big_s0(wv_q[0])
            + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = base_q[i] + wv_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hash_q  <= sha_pkg::InitHash;
      bits_q  <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
      two_q   <= 1'b0;
      snap_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.kind)
              sha_pkg::CMD_ABSORB: begin
                fill_q <= fill_q + 1'b1;
                bits_q <= bits_q + 64'd8;
                if (fill_q == 6'd63) begin
                  snap_q  <= 1'b0;
                  rnd_q   <= '0;
                  state_q <= ST_ROUND;
                end
              end
              sha_pkg::CMD_INIT: begin
                hash_q <= sha_pkg::InitHash;
                bits_q <= '0;
                fill_q <= '0;
              end
              default: begin
                snap_q  <= 1'b1;
                first_q <= 1'b1;
                two_q   <= (fill_q >= sha_pkg::LenStart);
                cnt_q   <= fill_q;
                state_q <= ST_PAD;
              end
            endcase
          end
        end
        ST_PAD: begin
          first_q <= 1'b0;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) begin
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!snap_q) begin
            hash_q  <= sum;
            state_q <= ST_IDLE;
          end else if (two_q) begin
            two_q   <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_PAD;
          end else begin
            idx_q   <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == sha_pkg::CMD_ABSORB) begin
            buf_q <= {buf_q[503:0], cmd_i.data};
            w_q   <= {buf_q[503:0], cmd_i.data};
            base_q <= hash_q;
            wv_q   <= hash_q;
          end else if (cmd_i.kind == sha_pkg::CMD_SNAP) begin
            w_q    <= buf_q;
            len_q  <= bits_q;
            base_q <= hash_q;
          end
        end
      end
      ST_PAD: begin
        w_q  <= {w_q[503:0], pad_byte};
        wv_q <= base_q;
        if (!first_q && !two_q && cnt_q >= sha_pkg::LenStart) begin
          len_q <= {len_q[55:0], 8'h00};
        end
      end
      ST_ROUND: begin
        w_q     <= {w_q[479:0], w_new};
        wv_q[7] <= wv_q[6];
        wv_q[6] <= wv_q[5];
        wv_q[5] <= wv_q[4];
        wv_q[4] <= wv_q[3] + t1;
        wv_q[3] <= wv_q[2];
        wv_q[2] <= wv_q[1];
        wv_q[1] <= wv_q[0];
        wv_q[0] <= t1 + t2;
      end
      ST_FINISH: begin
        base_q <= sum;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[src/sha256_stream_hasher.sv]
// top level of the streaming sha-256 hasher: front stage, command queue, hashing core
// depends on sha_pkg, sha_front, sha_queue, sha_core
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid_i/tready_o     tdata = data_byte, tuser = mode
// m_axis    out  m_axis_tvalid_o/tready_i     tdata = digest_word, word_index; tlast = last_word
//
// an absorb is taken in the core's idle state; every 64th byte also starts a
// compression (64 rounds at one per cycle plus a feed-forward add)
// an init is taken in the idle state; a snapshot pads from the current fill to the block
// end and compresses, again with a second block when fill is 56 or more, then eight output items
// the round loop is the limit: one shared round unit runs one round per cycle
// reset is asynchronous and active low; hash words go to the standard initial values
// the front register and a two-entry queue keep taking items while the core is busy
`default_nettype none
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic             m_axis_tlast_o    // last_word
);

  sha_pkg::cmd_t front_cmd, queue_cmd;
  logic          front_valid, front_ready;
  logic          queue_valid, queue_ready;
  logic [31:0]   word;
  logic [2:0]    index;

  // classify the mode of each item
  sha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // decouples the front from the compression loop
  sha_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_cmd_o   (queue_cmd)
  );

  // buffer, padding, rounds and digest output
  sha_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (word),
    .out_index_o (index),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, index, word};

endmodule
`default_nettype wire

[tb/sha256_stream_hasher_test.sv]
// self-checking bench for the streaming sha-256 hasher: byte absorb, init, padded snapshot
// depends on sha_pkg and sha256_stream_hasher; the scoreboard class keeps its own hash state
`default_nettype none
module sha256_stream_hasher_test;

  localparam int unsigned ItemCount = 410;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [63:0] length_bits;
    logic [7:0]  pending[64];
    int unsigned pending_fill;
    digest_item_t expected_words[$];
    int unsigned error_count;
    int unsigned digest_count;
    int unsigned byte_count;

    function new();
      restart();
      error_count = 0;
      digest_count = 0;
      byte_count = 0;
    endfunction

    function void restart();
      chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
      chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
      chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
      chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
      length_bits = '0;
      pending_fill = 0;
      foreach (pending[i]) pending[i] = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int r);
      return (x >> r) | (x << (32 - r));
    endfunction

    function logic [31:0] k_const(int t);
      logic [31:0] kt[64];
      kt = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return kt[t];
    endfunction

    // one 64-round compression folded into hv
    function void compress(ref logic [31:0] hv[8], input logic [7:0] blk[64]);
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
             + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      v = hv;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hv[i] += v[i];
    endfunction

    function void note_item(sha_pkg::mode_e mode, logic [7:0] data);
      logic [31:0] hv[8];
      logic [7:0]  blk[64];
      int unsigned fill;
      digest_item_t d;
      case (mode)
        sha_pkg::MODE_ABSORB: begin
          pending[pending_fill] = data;
          length_bits += 64'd8;
          byte_count++;
          pending_fill = (pending_fill + 1) % 64;
          if (pending_fill == 0) compress(chain, pending);
        end
        sha_pkg::MODE_INIT: restart();
        sha_pkg::MODE_SNAPSHOT: begin
          hv = chain;
          blk = pending;
          fill = pending_fill;
          blk[fill] = 8'h80;
          fill++;
          if (fill > 56) begin
            while (fill < 64) begin
              blk[fill] = '0;
              fill++;
            end
            compress(hv, blk);
            fill = 0;
          end
          while (fill < 56) begin
            blk[fill] = '0;
            fill++;
          end
          for (int i = 0; i < 8; i++) blk[56+i] = length_bits[63-8*i -: 8];
          compress(hv, blk);
          for (int i = 0; i < 8; i++) begin
            d.word = hv[i];
            d.index = 3'(i);
            d.last = (i == 7);
            expected_words.push_back(d);
          end
          digest_count++;
        end
        default: ;  // unused mode leaves everything alone
      endcase
    endfunction

    function void check_word(logic [39:0] tdata, logic tlast);
      digest_item_t d;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", tdata[31:0]);
        error_count++;
        return;
      end
      d = expected_words.pop_front();
      if (tdata[31:0] !== d.word) begin
        $error("digest_word: expected %h, got %h", d.word, tdata[31:0]);
        error_count++;
      end
      if (tdata[34:32] !== d.index) begin
        $error("word_index: expected %0d, got %0d", d.index, tdata[34:32]);
        error_count++;
      end
      if (tlast !== d.last) begin
        $error("last_word: expected %0b, got %0b", d.last, tlast);
        error_count++;
      end
      if (tdata[39:35] !== '0) begin
        $error("tdata pad bits: expected 0, got %h", tdata[39:35]);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] digest_word, [34:32] word_index
  logic        m_axis_tlast_o;        // last_word

  // idling switched off during a calm stretch in the middle of the random part
  bit calm = 1'b0;
  digest_scoreboard board = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sha256_stream_hasher dut (.*);

  // output side: random stall, check on the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_word(m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 9);
  end

  // send one item, with an optional idle cycle beforehand
  task automatic send_item(sha_pkg::mode_e mode, logic [7:0] data);
    if (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= mode;
    s_axis_tdata_i <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_item(mode, data);
    @(negedge clk_i);
  endtask

  task automatic send_bytes(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(sha_pkg::MODE_ABSORB, 8'($urandom));
  endtask

  int unsigned sent;

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty message, byte extremes, ignored mode, init, empty message after init
    send_item(sha_pkg::MODE_SNAPSHOT, 8'hff);
    send_item(sha_pkg::MODE_ABSORB, 8'h00);
    send_item(sha_pkg::MODE_ABSORB, 8'hff);
    send_item(sha_pkg::MODE_UNUSED, 8'ha5);
    send_item(sha_pkg::MODE_SNAPSHOT, 8'h00);
    send_item(sha_pkg::MODE_INIT, 8'h5a);
    send_item(sha_pkg::MODE_SNAPSHOT, 8'h00);
    sent = 7;

    // random: mostly byte runs of random length with snapshots, some inits and noise
    while (sent < ItemCount) begin
      int unsigned len;
      int unsigned pick;
      pick = $urandom_range(99);
      calm = (sent > 150 && sent < 230);
      if (pick < 70) begin
        // favor run lengths near the padding boundary (55 to 64 bytes)
        len = ($urandom_range(3) == 0) ? 55 + $urandom_range(9) : $urandom_range(20);
        send_bytes(len);
        send_item(sha_pkg::MODE_SNAPSHOT, 8'($urandom));
        sent += len + 1;
      end else if (pick < 85) begin
        send_item(sha_pkg::MODE_INIT, 8'($urandom));
        sent++;
      end else begin
        send_item(sha_pkg::MODE_UNUSED, 8'($urandom));
        send_item(sha_pkg::MODE_SNAPSHOT, 8'($urandom));
        sent += 2;
      end
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d bytes and %0d digests over random fills and stalls",
             board.byte_count, board.digest_count);
    if (board.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_core.sv
src/sha256_stream_hasher.sv
tb/sha256_stream_hasher_test.sv
